[rtl/core/pdpmc_pkg.sv]
// ============================================================================
// pdpmc_pkg
// Shared types and constants of the PD position motor controller.
// ============================================================================
`default_nettype none

package pdpmc_pkg;

    localparam int unsigned DATA_W  = 32;  // gains, positions, APB data
    localparam int unsigned ERR_W   = 33;  // position error
    localparam int unsigned DIFF_W  = 34;  // error change
    localparam int unsigned LVL_W   = 16;  // PWM level, pwm_top, supply
    localparam int unsigned DEN_W   = 24;  // supply in Q8.8 shifted to Q8.16
    localparam int unsigned PROD_W  = 64;  // drive magnitude
    localparam int unsigned PP_W    = 49;  // 32 x 17 partial product
    localparam int unsigned NUM_W   = 40;  // scaled drive before division
    localparam int unsigned ADDR_W  = 5;   // APB byte address
    localparam int unsigned STEP_W  = 4;   // sequencer step counter
    localparam int unsigned DIV_STEPS = 16;

    localparam logic [LVL_W-1:0] PWM_TOP_RESET = 16'd6249;

    // Register index, taken from paddr[4:2]
    typedef enum logic [2:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_PWM_TOP      = 3'd2,
        REG_INVERT_LEFT  = 3'd3,
        REG_INVERT_RIGHT = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] deriv_gain;
        logic [LVL_W-1:0]  pwm_top;
        logic              invert_left;
        logic              invert_right;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_MUL,
        ST_ACC,
        ST_COMB,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       calc_err;
        logic       calc_diff;
        logic       mul;
        logic       acc;
        logic [1:0] mul_sel;
        logic       comb;
        logic       scale;
        logic       div_step;
        logic       load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic sat;
    } t_sts;

endpackage

`default_nettype wire

[rtl/core/pdpmc_regs.sv]
// ============================================================================
// pdpmc_regs
// APB configuration registers: gains, PWM full scale, encoder inversion.
// ============================================================================
`default_nettype none

module pdpmc_regs (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdpmc_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [pdpmc_pkg::DATA_W-1:0]  pwdata,
    output logic      [pdpmc_pkg::DATA_W-1:0]  prdata,
    output logic                               pready,
    output pdpmc_pkg::t_cfg                    o_cfg
);

    pdpmc_pkg::t_cfg      r_cfg;
    pdpmc_pkg::t_reg_idx  w_idx;
    logic                 w_wr;

    assign w_idx  = pdpmc_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain    <= '0;
            r_cfg.deriv_gain   <= '0;
            r_cfg.pwm_top      <= pdpmc_pkg::PWM_TOP_RESET;
            r_cfg.invert_left  <= 1'b0;
            r_cfg.invert_right <= 1'b0;
        end else if (w_wr) begin
            unique case (w_idx)
                pdpmc_pkg::REG_PROP_GAIN:    r_cfg.prop_gain    <= pwdata;
                pdpmc_pkg::REG_DERIV_GAIN:   r_cfg.deriv_gain   <= pwdata;
                pdpmc_pkg::REG_PWM_TOP:      r_cfg.pwm_top      <= pwdata[15:0];
                pdpmc_pkg::REG_INVERT_LEFT:  r_cfg.invert_left  <= pwdata[0];
                pdpmc_pkg::REG_INVERT_RIGHT: r_cfg.invert_right <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            pdpmc_pkg::REG_PROP_GAIN:    prdata = r_cfg.prop_gain;
            pdpmc_pkg::REG_DERIV_GAIN:   prdata = r_cfg.deriv_gain;
            pdpmc_pkg::REG_PWM_TOP:      prdata = {16'd0, r_cfg.pwm_top};
            pdpmc_pkg::REG_INVERT_LEFT:  prdata = {31'd0, r_cfg.invert_left};
            pdpmc_pkg::REG_INVERT_RIGHT: prdata = {31'd0, r_cfg.invert_right};
            default:                     prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/pdpmc_dp.sv]
// ============================================================================
// pdpmc_dp
// Datapath: error, PD drive through a shared 32x17 multiplier, PWM scaling
// and a restoring divider; holds the per-motor previous error.
// ============================================================================
`default_nettype none

module pdpmc_dp #(
    parameter int unsigned NUM_MOTORS = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire pdpmc_pkg::t_cmd                     i_cmd,
    input  wire pdpmc_pkg::t_cfg                     i_cfg,
    input  wire logic                                i_motor_select,
    input  wire logic signed [pdpmc_pkg::DATA_W-1:0] i_target_position,
    input  wire logic signed [pdpmc_pkg::DATA_W-1:0] i_encoder_count,
    input  wire logic        [pdpmc_pkg::LVL_W-1:0]  i_supply_voltage,
    output pdpmc_pkg::t_sts                          o_sts,
    output logic             [pdpmc_pkg::LVL_W-1:0]  o_pwm_level,
    output logic                                     o_direction,
    output logic signed      [pdpmc_pkg::DATA_W-1:0] o_position,
    output logic signed      [pdpmc_pkg::ERR_W-1:0]  o_position_error
);

    localparam int unsigned SEL_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    // Input item
    logic [SEL_W-1:0]              r_idx;
    logic                          r_inv;
    logic [pdpmc_pkg::DATA_W-1:0]  r_target;
    logic [pdpmc_pkg::DATA_W-1:0]  r_raw;
    logic [pdpmc_pkg::LVL_W-1:0]   r_supply;
    // Error stage
    logic [pdpmc_pkg::DATA_W-1:0]  r_pos;
    logic [pdpmc_pkg::ERR_W-1:0]   r_err;
    logic [pdpmc_pkg::ERR_W-1:0]   r_prev [NUM_MOTORS];
    // Magnitudes and signs
    logic [pdpmc_pkg::DATA_W-1:0]  r_err_mag;
    logic [pdpmc_pkg::ERR_W-1:0]   r_diff_mag;
    logic [pdpmc_pkg::DATA_W-1:0]  r_gp_mag;
    logic [pdpmc_pkg::DATA_W-1:0]  r_gd_mag;
    logic                          r_neg_p;
    logic                          r_neg_d;
    // Products
    logic [pdpmc_pkg::PP_W-1:0]    r_pp;
    logic [pdpmc_pkg::PROD_W-1:0]  r_prod_p;
    logic [pdpmc_pkg::PROD_W-1:0]  r_prod_d;
    logic [pdpmc_pkg::PROD_W-1:0]  r_dmag;
    logic                          r_dneg;
    // Scaling and division
    logic                          r_sat;
    logic [pdpmc_pkg::DEN_W-1:0]   r_rem;
    logic [pdpmc_pkg::LVL_W-1:0]   r_q;

    logic [SEL_W-1:0]              w_idx;
    logic [pdpmc_pkg::DATA_W-1:0]  w_pos;
    logic [pdpmc_pkg::ERR_W-1:0]   w_err;
    logic [pdpmc_pkg::DIFF_W-1:0]  w_diff;
    logic [pdpmc_pkg::DATA_W-1:0]  w_op_a;
    logic [16:0]                   w_op_b;
    logic [pdpmc_pkg::PROD_W:0]    w_sum;
    logic [pdpmc_pkg::DEN_W-1:0]   w_den;
    logic [pdpmc_pkg::NUM_W-1:0]   w_num;
    logic [pdpmc_pkg::DEN_W:0]     w_trial;
    logic                          w_ge;

    assign w_idx = (NUM_MOTORS > 1) ? SEL_W'(i_motor_select) : '0;

    // Inversion wraps in 32 bits; error is exact in 33
    assign w_pos = r_inv ? 32'(32'd0 - r_raw) : r_raw;
    assign w_err = {r_target[31], r_target} - {w_pos[31], w_pos};
    assign w_diff = {r_err[32], r_err} - {r_prev[r_idx][32], r_prev[r_idx]};

    always_comb begin
        w_op_a = i_cmd.mul_sel[1] ? r_gd_mag : r_gp_mag;
        unique case (i_cmd.mul_sel)
            2'd0:    w_op_b = {1'b0, r_err_mag[15:0]};
            2'd1:    w_op_b = {1'b0, r_err_mag[31:16]};
            2'd2:    w_op_b = {1'b0, r_diff_mag[15:0]};
            default: w_op_b = r_diff_mag[32:16];
        endcase
    end

    assign w_sum   = {1'b0, r_prod_p} + {1'b0, r_prod_d};
    assign w_den   = {r_supply, 8'd0};
    assign w_num   = r_dmag[23:0] * i_cfg.pwm_top;
    assign w_trial = {r_rem, r_q[15]};
    assign w_ge    = (w_trial >= {1'b0, w_den});

    assign o_sts.sat = (r_supply == '0) || (r_dmag >= 64'(w_den));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_idx    <= w_idx;
            r_inv    <= (NUM_MOTORS == 1 || !i_motor_select) ? i_cfg.invert_left
                                                              : i_cfg.invert_right;
            r_target <= i_target_position;
            r_raw    <= i_encoder_count;
            r_supply <= i_supply_voltage;
        end
        if (i_cmd.calc_err) begin
            r_pos <= w_pos;
            r_err <= w_err;
        end
        if (i_cmd.calc_diff) begin
            r_err_mag  <= r_err[32] ? 32'(33'd0 - r_err) : r_err[31:0];
            r_diff_mag <= w_diff[33] ? 33'(34'd0 - w_diff) : w_diff[32:0];
            r_gp_mag   <= i_cfg.prop_gain[31] ? 32'(32'd0 - i_cfg.prop_gain)
                                              : i_cfg.prop_gain;
            r_gd_mag   <= i_cfg.deriv_gain[31] ? 32'(32'd0 - i_cfg.deriv_gain)
                                               : i_cfg.deriv_gain;
            r_neg_p    <= i_cfg.prop_gain[31] ^ r_err[32];
            r_neg_d    <= i_cfg.deriv_gain[31] ^ w_diff[33];
        end
        if (i_cmd.mul) begin
            r_pp <= w_op_a * w_op_b;
        end
        if (i_cmd.acc) begin
            unique case (i_cmd.mul_sel)
                2'd0:    r_prod_p <= 64'(r_pp);
                2'd1:    r_prod_p <= r_prod_p + (64'(r_pp) << 16);
                2'd2:    r_prod_d <= 64'(r_pp);
                default: r_prod_d <= r_prod_d + (64'(r_pp) << 16);
            endcase
        end
        if (i_cmd.comb) begin
            // Signed sum of the two terms as sign and saturated magnitude
            if (r_neg_p == r_neg_d) begin
                r_dmag <= w_sum[64] ? '1 : w_sum[63:0];
                r_dneg <= r_neg_p;
            end else if (r_prod_p >= r_prod_d) begin
                r_dmag <= r_prod_p - r_prod_d;
                r_dneg <= r_neg_p;
            end else begin
                r_dmag <= r_prod_d - r_prod_p;
                r_dneg <= r_neg_d;
            end
        end
        if (i_cmd.scale) begin
            r_sat <= o_sts.sat;
            r_rem <= w_num[39:16];
            r_q   <= w_num[15:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? 24'(w_trial - {1'b0, w_den}) : w_trial[23:0];
            r_q   <= {r_q[14:0], w_ge};
        end
        if (i_cmd.load_out) begin
            o_pwm_level      <= r_sat ? i_cfg.pwm_top : r_q;
            o_direction      <= !r_dneg && (r_dmag != '0);
            o_position       <= r_pos;
            o_position_error <= r_err;
        end
    end

    // Previous error per motor, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_MOTORS; i++) begin
                r_prev[i] <= '0;
            end
        end else if (i_cmd.load_out) begin
            r_prev[r_idx] <= r_err;
        end
    end

endmodule

`default_nettype wire

[rtl/core/pdpmc_ctrl.sv]
// ============================================================================
// pdpmc_ctrl
// Sequencer: steps the datapath through one item and owns both handshakes.
// ============================================================================
`default_nettype none

module pdpmc_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    input  wire pdpmc_pkg::t_sts i_sts,
    output pdpmc_pkg::t_cmd  o_cmd
);

    localparam logic [pdpmc_pkg::STEP_W-1:0] STEP_LAST =
        pdpmc_pkg::STEP_W'(pdpmc_pkg::DIV_STEPS - 1);

    pdpmc_pkg::t_state             r_state;
    pdpmc_pkg::t_state             n_state;
    logic [pdpmc_pkg::STEP_W-1:0]  r_step;
    logic [pdpmc_pkg::STEP_W-1:0]  n_step;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic                          w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != pdpmc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdpmc_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            pdpmc_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = pdpmc_pkg::ST_ERR;
                end
            end
            pdpmc_pkg::ST_ERR:  n_state = pdpmc_pkg::ST_DIFF;
            pdpmc_pkg::ST_DIFF: begin
                n_state = pdpmc_pkg::ST_MUL;
                n_step  = '0;
            end
            pdpmc_pkg::ST_MUL:  n_state = pdpmc_pkg::ST_ACC;
            pdpmc_pkg::ST_ACC: begin
                n_step = r_step + 1'b1;
                if (r_step == 4'd3) begin
                    n_state = pdpmc_pkg::ST_COMB;
                end else begin
                    n_state = pdpmc_pkg::ST_MUL;
                end
            end
            pdpmc_pkg::ST_COMB: n_state = pdpmc_pkg::ST_SCALE;
            pdpmc_pkg::ST_SCALE: begin
                n_step = '0;
                if (i_sts.sat) begin
                    n_state = pdpmc_pkg::ST_DONE;
                end else begin
                    n_state = pdpmc_pkg::ST_DIV;
                end
            end
            pdpmc_pkg::ST_DIV: begin
                n_step = r_step + 1'b1;
                if (r_step == STEP_LAST) begin
                    n_state = pdpmc_pkg::ST_DONE;
                end
            end
            pdpmc_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = pdpmc_pkg::ST_IDLE;
                end
            end
            default: n_state = pdpmc_pkg::ST_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = r_step[1:0];
        unique case (r_state)
            pdpmc_pkg::ST_IDLE:  o_cmd.load_in   = i_in_valid;
            pdpmc_pkg::ST_ERR:   o_cmd.calc_err  = 1'b1;
            pdpmc_pkg::ST_DIFF:  o_cmd.calc_diff = 1'b1;
            pdpmc_pkg::ST_MUL:   o_cmd.mul       = 1'b1;
            pdpmc_pkg::ST_ACC:   o_cmd.acc       = 1'b1;
            pdpmc_pkg::ST_COMB:  o_cmd.comb      = 1'b1;
            pdpmc_pkg::ST_SCALE: o_cmd.scale     = 1'b1;
            pdpmc_pkg::ST_DIV:   o_cmd.div_step  = 1'b1;
            pdpmc_pkg::ST_DONE:  o_cmd.load_out  = w_out_free;
            default: ;
        endcase
    end

    // Output item holds until taken
    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);

endmodule

`default_nettype wire

[rtl/core/pd_position_motor_control.sv]
// ============================================================================
// pd_position_motor_control
// PD position controller for up to NUM_MOTORS motors with PWM level output.
// ============================================================================
// Sequence: error, difference, multiply/accumulate on the shared 32x17
//   multiplier (four partial products), combine, scale and the 16-step
//   restoring divider, which is skipped when the level saturates (zero supply
//   or drive at full scale). A new item waits until the result is loaded.
// Reset (synchronous, active low): registers to their reset values, previous
//   errors of all motors to zero, no output item pending.
`default_nettype none

module pd_position_motor_control #(
    parameter int unsigned NUM_MOTORS = 2
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input item channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_motor_select,
    input  wire logic signed [pdpmc_pkg::DATA_W-1:0] i_target_position,
    input  wire logic signed [pdpmc_pkg::DATA_W-1:0] i_encoder_count,
    input  wire logic        [pdpmc_pkg::LVL_W-1:0]  i_supply_voltage,
    // Result item channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic             [pdpmc_pkg::LVL_W-1:0]  o_pwm_level,
    output logic                                     o_direction,
    output logic signed      [pdpmc_pkg::DATA_W-1:0] o_position,
    output logic signed      [pdpmc_pkg::ERR_W-1:0]  o_position_error,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic        [pdpmc_pkg::ADDR_W-1:0] paddr,
    input  wire logic        [pdpmc_pkg::DATA_W-1:0] pwdata,
    output logic             [pdpmc_pkg::DATA_W-1:0] prdata,
    output logic                                     pready
);

    pdpmc_pkg::t_cfg w_cfg;
    pdpmc_pkg::t_cmd w_cmd;
    pdpmc_pkg::t_sts w_sts;

    // Register file: gains, PWM full scale, inversion bits
    pdpmc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Sequencer: accept an item only when idle, then walk the datapath through
    // error, difference, multiply/accumulate, combine, scale, divide unless saturated.
    pdpmc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: drive magnitude kept as sign plus 64-bit saturated value,
    // level = drive * pwm_top / (supply << 8) when below full scale.
    pdpmc_dp #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_cfg             (w_cfg),
        .i_motor_select    (i_motor_select),
        .i_target_position (i_target_position),
        .i_encoder_count   (i_encoder_count),
        .i_supply_voltage  (i_supply_voltage),
        .o_sts             (w_sts),
        .o_pwm_level       (o_pwm_level),
        .o_direction       (o_direction),
        .o_position        (o_position),
        .o_position_error  (o_position_error)
    );

    // An accepted item locks out the input channel on the next cycle
    a_accept_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepting an item");

    // A result appears only after the sequencer loaded it
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid without a result load");

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a stalled output item");

endmodule

`default_nettype wire
